// ===== hdl/srrw_pkg.sv =====
// shared types and constants of the selective-repeat receive window
package srrw_pkg;

  localparam int WINDOW    = 64;
  localparam int SACK_W    = 32;

  localparam int SEQ_W   = 32;
  localparam int TAG_W   = 16;
  localparam int LEN_W   = 11;
  localparam int WS_W    = 6;
  localparam int KIND_W  = 2;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;
  localparam int IDX_W   = $clog2(WINDOW);
  localparam int CNT_W   = $clog2(WINDOW + 1);
  localparam int LIM_W   = 7;

  typedef enum logic [KIND_W-1:0] {
    KIND_RELEASE   = 2'd0,
    KIND_SACK_ACK  = 2'd1,
    KIND_PLAIN_ACK = 2'd2,
    KIND_FIN_ACK   = 2'd3
  } kind_t;

  localparam logic [1:0] REG_WINDOW_SIZE = 2'd0;
  localparam logic [1:0] REG_START_SEQ   = 2'd1;
  localparam logic [1:0] REG_LOCAL_SEQ   = 2'd2;

  typedef struct packed {
    logic             valid;
    logic [TAG_W-1:0] tag;
    logic [LEN_W-1:0] len;
  } slot_t;

  typedef struct packed {
    logic shift;
    logic clear;
    logic wr;
  } cell_ctrl_t;

endpackage

// ===== hdl/srrw_cell.sv =====
// one window cell: holds the entry at a fixed distance from the expected sequence
module srrw_cell (
  input  logic                     clk,
  input  logic                     rst_n,
  input  srrw_pkg::cell_ctrl_t     ctrl,
  input  srrw_pkg::slot_t          from_up,
  input  logic [srrw_pkg::TAG_W-1:0] in_tag,
  input  logic [srrw_pkg::LEN_W-1:0] in_len,
  output srrw_pkg::slot_t          slot
);
  import srrw_pkg::*;

  logic             valid_r;
  logic             valid_nxt;
  logic [TAG_W-1:0] tag_r;
  logic [TAG_W-1:0] tag_nxt;
  logic [LEN_W-1:0] len_r;
  logic [LEN_W-1:0] len_nxt;
  logic             load;

  // first copy is kept
  assign load = ctrl.wr && !valid_r;

  always_comb begin
    if (ctrl.clear) begin
      valid_nxt = 1'b0;
    end else if (ctrl.shift) begin
      valid_nxt = from_up.valid;
    end else if (load) begin
      valid_nxt = 1'b1;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_comb begin
    if (ctrl.shift) begin
      tag_nxt = from_up.tag;
      len_nxt = from_up.len;
    end else if (load) begin
      tag_nxt = in_tag;
      len_nxt = in_len;
    end else begin
      tag_nxt = tag_r;
      len_nxt = len_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tag_r <= tag_nxt;
    len_r <= len_nxt;
  end

  assign slot.valid = valid_r;
  assign slot.tag   = tag_r;
  assign slot.len   = len_r;

endmodule

// ===== hdl/selective_repeat_receive_window.sv =====
// top level: selective-repeat receive window with sack bitmap over a row of shifting cells
// data packet: each in-order entry released, then a sack ack; busy until the sack ack
// first result is registered in the state entered at the accepting edge, then one per cycle
// fin packet: plain ack then fin-ack, busy meanwhile; closed block takes one per cycle
// results are strobed for one cycle by out_valid and cannot be stalled
// synchronous active-low reset clears the window, counters and closed flag at once
module selective_repeat_receive_window (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_cmd,
  input  logic [srrw_pkg::SEQ_W-1:0]    in_seq,
  input  logic [srrw_pkg::TAG_W-1:0]    in_payload_tag,
  input  logic [srrw_pkg::LEN_W-1:0]    in_payload_len,
  output logic                          out_valid,
  output logic [srrw_pkg::KIND_W-1:0]   out_kind,
  output logic [srrw_pkg::TAG_W-1:0]    out_release_tag,
  output logic [srrw_pkg::LEN_W-1:0]    out_release_len,
  output logic [srrw_pkg::SEQ_W-1:0]    out_own_seq,
  output logic [srrw_pkg::SEQ_W-1:0]    out_ack_number,
  output logic [srrw_pkg::WS_W-1:0]     out_free_window,
  output logic [srrw_pkg::SACK_W-1:0]   out_sack_map,
  output logic                          out_last,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [srrw_pkg::ADDR_W-1:0]   paddr,
  input  logic [srrw_pkg::DATA_W-1:0]   pwdata,
  output logic [srrw_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import srrw_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DRAIN,
    ST_FIN_ACK,
    ST_FIN_CLOSE
  } state_t;

  state_t             state_r;
  logic [WS_W-1:0]    window_size_r;
  logic [SEQ_W-1:0]   start_seq_r;
  logic [SEQ_W-1:0]   local_seq_r;
  logic [SEQ_W-1:0]   expected_r;
  logic [SEQ_W-1:0]   expected_nxt;
  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   count_nxt;
  logic               closed_r;
  logic               closed_nxt;

  logic               out_valid_r;
  kind_t              out_kind_r;
  logic [TAG_W-1:0]   out_tag_r;
  logic [LEN_W-1:0]   out_len_r;
  logic [SEQ_W-1:0]   out_own_r;
  logic [SEQ_W-1:0]   out_ack_r;
  logic [WS_W-1:0]    out_fw_r;
  logic [SACK_W-1:0]  out_sack_r;
  logic               out_last_r;

  logic               accept;
  logic               live;
  logic               cfg_wr;
  logic [1:0]         cfg_idx;
  logic               start_wr;
  logic [SEQ_W-1:0]   seq_off;
  logic [LIM_W-1:0]   lim;
  logic               in_win;
  logic               data_wr;
  logic               release_now;
  logic [SEQ_W-1:0]   fin_next;
  logic [SEQ_W-1:0]   fin_dist;
  logic               fin_raise;
  logic [LIM_W-1:0]   fw_wide;
  logic [WS_W-1:0]    free_win;
  logic [WINDOW-1:0]  valid_vec;
  logic [WINDOW-1:0]  wr_vec;
  logic               hit_taken;
  logic [SACK_W-1:0]  sack_vec;

  slot_t              slot_q  [WINDOW];
  slot_t              from_up [WINDOW];
  cell_ctrl_t         ctrl    [WINDOW];

  // configuration port
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign cfg_idx  = paddr[3:2];
  assign start_wr = cfg_wr && (cfg_idx == REG_START_SEQ);

  always_comb begin
    case (cfg_idx)
      REG_WINDOW_SIZE: prdata = DATA_W'(window_size_r);
      REG_START_SEQ:   prdata = start_seq_r;
      REG_LOCAL_SEQ:   prdata = local_seq_r;
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_size_r <= WS_W'(32);
      start_seq_r   <= '0;
      local_seq_r   <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_WINDOW_SIZE: window_size_r <= pwdata[WS_W-1:0];
        REG_START_SEQ:   start_seq_r   <= pwdata;
        REG_LOCAL_SEQ:   local_seq_r   <= pwdata;
        default:         ;
      endcase
    end
  end

  // transaction decode
  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;
  assign live   = accept && !closed_r;

  assign seq_off = in_seq - expected_r;
  assign lim    = (LIM_W'(window_size_r) < LIM_W'(WINDOW)) ? LIM_W'(window_size_r)
                                                           : LIM_W'(WINDOW);
  assign in_win  = (seq_off[SEQ_W-1:LIM_W] == '0) && (seq_off[LIM_W-1:0] < lim);
  assign data_wr = live && !in_cmd && in_win;

  assign fin_next  = in_seq + SEQ_W'(1);
  assign fin_dist  = fin_next - expected_r;
  assign fin_raise = (fin_dist != '0) && !fin_dist[SEQ_W-1];

  assign release_now = (state_r == ST_DRAIN) && slot_q[0].valid;

  // cell row
  genvar gi;
  generate
    for (gi = 0; gi < WINDOW; gi++) begin : g_cell
      if (gi == WINDOW - 1) begin : g_end
        assign from_up[gi] = '0;
      end else begin : g_mid
        assign from_up[gi] = slot_q[gi+1];
      end
      assign wr_vec[gi]     = data_wr && (seq_off[IDX_W-1:0] == IDX_W'(gi));
      assign ctrl[gi].shift = release_now;
      assign ctrl[gi].clear = start_wr;
      assign ctrl[gi].wr    = wr_vec[gi];
      assign valid_vec[gi]  = slot_q[gi].valid;

      srrw_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl[gi]),
        .from_up (from_up[gi]),
        .in_tag  (in_payload_tag),
        .in_len  (in_payload_len),
        .slot    (slot_q[gi])
      );
    end

    for (gi = 0; gi < SACK_W; gi++) begin : g_sack
      if (gi + 1 < WINDOW) begin : g_on
        assign sack_vec[gi] = slot_q[gi+1].valid;
      end else begin : g_off
        assign sack_vec[gi] = 1'b0;
      end
    end
  endgenerate

  assign hit_taken = |(wr_vec & valid_vec);

  assign fw_wide  = (LIM_W'(window_size_r) > LIM_W'(count_r))
                  ? (LIM_W'(window_size_r) - LIM_W'(count_r)) : '0;
  assign free_win = fw_wide[WS_W-1:0];

  // window bookkeeping
  always_comb begin
    expected_nxt = expected_r;
    count_nxt    = count_r;
    closed_nxt   = closed_r;
    if (start_wr) begin
      expected_nxt = pwdata;
      count_nxt    = '0;
      closed_nxt   = 1'b0;
    end else if (live && in_cmd) begin
      closed_nxt = 1'b1;
      if (fin_raise) begin
        expected_nxt = fin_next;
      end
    end else if (data_wr && !hit_taken) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (release_now) begin
      expected_nxt = expected_r + SEQ_W'(1);
      if (count_r != '0) begin
        count_nxt = count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_r <= '0;
      count_r    <= '0;
      closed_r   <= 1'b0;
    end else begin
      expected_r <= expected_nxt;
      count_r    <= count_nxt;
      closed_r   <= closed_nxt;
    end
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (live) begin
            state_r <= in_cmd ? ST_FIN_ACK : ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          out_valid_r <= 1'b1;
          if (slot_q[0].valid) begin
            out_kind_r <= KIND_RELEASE;
            out_tag_r  <= slot_q[0].tag;
            out_len_r  <= slot_q[0].len;
            out_own_r  <= '0;
            out_ack_r  <= '0;
            out_fw_r   <= '0;
            out_sack_r <= '0;
            out_last_r <= 1'b0;
          end else begin
            out_kind_r <= KIND_SACK_ACK;
            out_tag_r  <= '0;
            out_len_r  <= '0;
            out_own_r  <= local_seq_r + SEQ_W'(1);
            out_ack_r  <= expected_r;
            out_fw_r   <= free_win;
            out_sack_r <= sack_vec;
            out_last_r <= 1'b1;
            state_r    <= ST_IDLE;
          end
        end
        ST_FIN_ACK: begin
          out_valid_r <= 1'b1;
          out_kind_r  <= KIND_PLAIN_ACK;
          out_tag_r   <= '0;
          out_len_r   <= '0;
          out_own_r   <= local_seq_r + SEQ_W'(1);
          out_ack_r   <= expected_r;
          out_fw_r    <= free_win;
          out_sack_r  <= '0;
          out_last_r  <= 1'b0;
          state_r     <= ST_FIN_CLOSE;
        end
        ST_FIN_CLOSE: begin
          out_valid_r <= 1'b1;
          out_kind_r  <= KIND_FIN_ACK;
          out_tag_r   <= '0;
          out_len_r   <= '0;
          out_own_r   <= local_seq_r + SEQ_W'(2);
          out_ack_r   <= expected_r;
          out_fw_r    <= free_win;
          out_sack_r  <= '0;
          out_last_r  <= 1'b1;
          state_r     <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_release_tag = out_tag_r;
  assign out_release_len = out_len_r;
  assign out_own_seq     = out_own_r;
  assign out_ack_number  = out_ack_r;
  assign out_free_window = out_fw_r;
  assign out_sack_map    = out_sack_r;
  assign out_last        = out_last_r;

  // stored counter tracks the occupied cells
  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_vec) == int'(count_r))
    else $error("stored count out of step with cell row");

  // every release advances the expected sequence by one
  a_release_advances: assert property (@(posedge clk) disable iff (!rst_n)
    (release_now && !start_wr) |=> (expected_r == $past(expected_r) + SEQ_W'(1)))
    else $error("release without sequence advance");

  // a closed block swallows items without starting work
  a_closed_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && closed_r) |=> (state_r == ST_IDLE))
    else $error("closed block started work");

endmodule

// ===== tb/testbench.sv =====
// testbench for the selective-repeat receive window: directed and random traffic, checked per field
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import srrw_pkg::*;

  localparam logic CMD_DATA = 1'b0;
  localparam logic CMD_FIN  = 1'b1;
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int QUIET_LIMIT = 3000;

  typedef struct {
    kind_t             kind;
    logic [TAG_W-1:0]  tag;
    logic [LEN_W-1:0]  len;
    logic [SEQ_W-1:0]  own_seq;
    logic [SEQ_W-1:0]  ack_number;
    logic [WS_W-1:0]   free_win;
    logic [SACK_W-1:0] sack;
    logic              last;
  } window_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic in_cmd = 1'b0;
  logic [SEQ_W-1:0] in_seq = '0;
  logic [TAG_W-1:0] in_payload_tag = '0;
  logic [LEN_W-1:0] in_payload_len = '0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic busy;
  logic out_valid;
  logic [KIND_W-1:0] out_kind;
  logic [TAG_W-1:0] out_release_tag;
  logic [LEN_W-1:0] out_release_len;
  logic [SEQ_W-1:0] out_own_seq;
  logic [SEQ_W-1:0] out_ack_number;
  logic [WS_W-1:0] out_free_window;
  logic [SACK_W-1:0] out_sack_map;
  logic out_last;
  logic [DATA_W-1:0] prdata;
  logic pready;

  // window state as the block should hold it
  logic [SEQ_W-1:0] rx_expected;
  logic             rx_slot_valid [WINDOW];
  logic [TAG_W-1:0] rx_slot_tag [WINDOW];
  logic [LEN_W-1:0] rx_slot_len [WINDOW];
  int               rx_stored;
  logic             rx_closed;
  logic [IDX_W-1:0] rx_head;
  logic [WS_W-1:0]  rx_window_size;
  logic [SEQ_W-1:0] rx_local_seq;

  window_result_t ack_release_q [$];
  int fault_count = 0;
  int quiet_cycles = 0;
  bit gaps_on = 1'b1;

  selective_repeat_receive_window uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_cmd          (in_cmd),
    .in_seq          (in_seq),
    .in_payload_tag  (in_payload_tag),
    .in_payload_len  (in_payload_len),
    .out_valid       (out_valid),
    .out_kind        (out_kind),
    .out_release_tag (out_release_tag),
    .out_release_len (out_release_len),
    .out_own_seq     (out_own_seq),
    .out_ack_number  (out_ack_number),
    .out_free_window (out_free_window),
    .out_sack_map    (out_sack_map),
    .out_last        (out_last),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void reopen_window(input logic [SEQ_W-1:0] first_seq);
    rx_expected = first_seq;
    for (int i = 0; i < WINDOW; i++) begin
      rx_slot_valid[i] = 1'b0;
    end
    rx_stored = 0;
    rx_head = '0;
    rx_closed = 1'b0;
  endfunction

  function automatic logic [WS_W-1:0] free_window();
    return (int'(rx_window_size) > rx_stored) ? WS_W'(int'(rx_window_size) - rx_stored) : '0;
  endfunction

  function automatic logic [SACK_W-1:0] sack_map();
    logic [SACK_W-1:0] bits;
    bits = '0;
    for (int i = 0; i < SACK_W; i++) begin
      if (i + 1 < WINDOW && rx_slot_valid[IDX_W'(int'(rx_head) + i + 1)]) begin
        bits[i] = 1'b1;
      end
    end
    return bits;
  endfunction

  function automatic void push_result(input kind_t kind, input logic [TAG_W-1:0] tag,
                                      input logic [LEN_W-1:0] len,
                                      input logic [SEQ_W-1:0] own_seq,
                                      input logic [SEQ_W-1:0] ack_number,
                                      input logic [WS_W-1:0] free_win,
                                      input logic [SACK_W-1:0] sack, input logic last);
    window_result_t r;
    r.kind = kind;
    r.tag = tag;
    r.len = len;
    r.own_seq = own_seq;
    r.ack_number = ack_number;
    r.free_win = free_win;
    r.sack = sack;
    r.last = last;
    ack_release_q.push_back(r);
  endfunction

  function automatic void predict_packet(input logic cmd, input logic [SEQ_W-1:0] seq,
                                         input logic [TAG_W-1:0] tag,
                                         input logic [LEN_W-1:0] len);
    logic [SEQ_W-1:0] offset;
    logic [SEQ_W-1:0] lead;
    logic [IDX_W-1:0] idx;
    logic [WS_W-1:0] fw;
    int n;
    if (rx_closed) return;
    if (cmd == CMD_DATA) begin
      offset = seq - rx_expected;
      if (offset < SEQ_W'(rx_window_size)) begin
        idx = IDX_W'(rx_head + offset[IDX_W-1:0]);
        if (!rx_slot_valid[idx]) begin
          rx_slot_valid[idx] = 1'b1;
          rx_slot_tag[idx] = tag;
          rx_slot_len[idx] = len;
          rx_stored++;
        end
      end
      n = 0;
      while (rx_slot_valid[rx_head] && n < WINDOW) begin
        push_result(KIND_RELEASE, rx_slot_tag[rx_head], rx_slot_len[rx_head], '0, '0, '0, '0,
                    1'b0);
        n++;
        rx_slot_valid[rx_head] = 1'b0;
        if (rx_stored > 0) rx_stored--;
        rx_expected++;
        rx_head++;
      end
      push_result(KIND_SACK_ACK, '0, '0, rx_local_seq + 1, rx_expected, free_window(),
                  sack_map(), 1'b1);
    end else begin
      lead = seq + 1 - rx_expected;
      if (lead != 0 && lead < 32'h8000_0000) rx_expected = seq + 1;
      fw = free_window();
      push_result(KIND_PLAIN_ACK, '0, '0, rx_local_seq + 1, rx_expected, fw, '0, 1'b0);
      push_result(KIND_FIN_ACK, '0, '0, rx_local_seq + 2, rx_expected, fw, '0, 1'b1);
      rx_closed = 1'b1;
    end
  endfunction

  task automatic drive_packet(input logic cmd, input logic [SEQ_W-1:0] seq,
                              input logic [TAG_W-1:0] tag, input logic [LEN_W-1:0] len);
    if (gaps_on && $urandom_range(99) < 24) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    start <= 1'b1;
    in_cmd <= cmd;
    in_seq <= seq;
    in_payload_tag <= tag;
    in_payload_len <= len;
    do @(posedge clk); while (busy);
    predict_packet(cmd, seq, tag, len);
  endtask

  task automatic park_until_drained();
    start <= 1'b0;
    while (ack_release_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [DATA_W-1:0] value);
    park_until_drained();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_WINDOW_SIZE: rx_window_size = value[WS_W-1:0];
      REG_START_SEQ:   reopen_window(value);
      REG_LOCAL_SEQ:   rx_local_seq = value;
      default: ;
    endcase
  endtask

  function automatic logic [SEQ_W-1:0] pick_seq();
    int r;
    int lim;
    r = $urandom_range(99);
    lim = rx_window_size;
    if (r < 55 && lim > 0) return rx_expected + $urandom_range(lim - 1);
    if (r < 70) return rx_expected;
    if (r < 80) return rx_expected + lim + $urandom_range(3);
    if (r < 90) return rx_expected - $urandom_range(1, 40);
    return $urandom;
  endfunction

  task automatic test_directed_edges();
    // reset values: window 32, expected 0, local 0
    drive_packet(CMD_DATA, 32'd0, 16'hFFFF, 11'h7FF);
    drive_packet(CMD_DATA, 32'd0, 16'h0000, 11'h000);
    drive_packet(CMD_DATA, 32'd3, 16'h1234, 11'd5);
    drive_packet(CMD_DATA, 32'd3, 16'hAAAA, 11'h555);
    drive_packet(CMD_DATA, 32'd32, 16'h5555, 11'h2AA);
    drive_packet(CMD_DATA, 32'd33, 16'h0F0F, 11'h0F0);
    drive_packet(CMD_DATA, 32'hFFFF_FFFF, 16'hF0F0, 11'h70F);
    drive_packet(CMD_DATA, 32'd2, 16'h8001, 11'h401);
    drive_packet(CMD_DATA, 32'd1, 16'h7FFE, 11'h3FE);
    drive_packet(CMD_FIN, 32'd10, 16'h0000, 11'h000);
    drive_packet(CMD_DATA, 32'd11, 16'h1111, 11'h111);
    drive_packet(CMD_FIN, 32'd40, 16'h2222, 11'h222);
    cfg_write(REG_START_SEQ, 32'h7FFF_FFFE);
    cfg_write(REG_LOCAL_SEQ, 32'hFFFF_FFFE);
    cfg_write(REG_WINDOW_SIZE, 32'd1);
    drive_packet(CMD_DATA, rx_expected + 1, 16'h3333, 11'h333);
    drive_packet(CMD_DATA, rx_expected, 16'h4444, 11'h444);
    drive_packet(CMD_FIN, rx_expected - 1, 16'h0000, 11'h000);
    cfg_write(REG_START_SEQ, 32'd5);
    cfg_write(REG_WINDOW_SIZE, 32'd0);
    drive_packet(CMD_DATA, 32'd5, 16'h6666, 11'h666);
    // fin half the sequence space ahead leaves the expected number alone
    drive_packet(CMD_FIN, rx_expected + 32'h7FFF_FFFF, 16'h0000, 11'h000);
    cfg_write(REG_START_SEQ, 32'd100);
    cfg_write(REG_UNUSED, 32'hFFFF_FFFF);
    cfg_write(REG_WINDOW_SIZE, 32'd63);
    drive_packet(CMD_FIN, rx_expected + 32'h7FFF_FFFE, 16'h0000, 11'h000);
  endtask

  task automatic test_window_shrink();
    logic [SEQ_W-1:0] base;
    cfg_write(REG_WINDOW_SIZE, 32'd40);
    cfg_write(REG_START_SEQ, 32'h0000_1000);
    cfg_write(REG_LOCAL_SEQ, $urandom);
    base = rx_expected;
    drive_packet(CMD_DATA, base + 10, 16'($urandom), 11'($urandom));
    drive_packet(CMD_DATA, base + 12, 16'($urandom), 11'($urandom));
    drive_packet(CMD_DATA, base + 20, 16'($urandom), 11'($urandom));
    drive_packet(CMD_DATA, base + 30, 16'($urandom), 11'($urandom));
    drive_packet(CMD_DATA, base + 39, 16'($urandom), 11'($urandom));
    drive_packet(CMD_DATA, base + 2, 16'($urandom), 11'($urandom));
    cfg_write(REG_WINDOW_SIZE, 32'd3);
    drive_packet(CMD_DATA, base + 1, 16'($urandom), 11'($urandom));
    drive_packet(CMD_DATA, base + 5, 16'($urandom), 11'($urandom));
    drive_packet(CMD_DATA, base + 2, 16'($urandom), 11'($urandom));
    drive_packet(CMD_DATA, base, 16'($urandom), 11'($urandom));
    drive_packet(CMD_DATA, rx_expected, 16'($urandom), 11'($urandom));
  endtask

  task automatic test_full_window_drain();
    logic [SEQ_W-1:0] order [$];
    logic [SEQ_W-1:0] base;
    logic [SEQ_W-1:0] held;
    int j;
    cfg_write(REG_WINDOW_SIZE, 32'd63);
    cfg_write(REG_START_SEQ, 32'hFFFF_FFE0);
    cfg_write(REG_LOCAL_SEQ, 32'hFFFF_FFFF);
    base = rx_expected;
    for (int i = 1; i < 63; i++) order.push_back(base + i);
    for (int i = order.size() - 1; i > 0; i--) begin
      j = $urandom_range(i);
      held = order[i];
      order[i] = order[j];
      order[j] = held;
    end
    foreach (order[i]) drive_packet(CMD_DATA, order[i], 16'($urandom), 11'($urandom));
    park_until_drained();
    drive_packet(CMD_DATA, base, 16'($urandom), 11'($urandom));
  endtask

  task automatic test_random_traffic();
    int sent;
    int phase;
    int n;
    int r;
    logic [SEQ_W-1:0] fin_seq;
    sent = 0;
    phase = 0;
    while (sent < 360) begin
      r = $urandom_range(99);
      if (r < 6) cfg_write(REG_WINDOW_SIZE, 32'd0);
      else if (r < 18) cfg_write(REG_WINDOW_SIZE, 32'd1);
      else if (r < 35) cfg_write(REG_WINDOW_SIZE, 32'd63);
      else cfg_write(REG_WINDOW_SIZE, $urandom_range(2, 62));
      cfg_write(REG_LOCAL_SEQ, $urandom);
      if ($urandom_range(3) == 0) cfg_write(REG_START_SEQ, 32'hFFFF_FFFF - $urandom_range(40));
      else cfg_write(REG_START_SEQ, $urandom);
      gaps_on = (phase != 3);
      n = gaps_on ? $urandom_range(20, 50) : 90;
      for (int i = 0; i < n; i++) begin
        if (gaps_on && $urandom_range(99) < 3) cfg_write(REG_WINDOW_SIZE, $urandom_range(63));
        drive_packet(CMD_DATA, pick_seq(), 16'($urandom), 11'($urandom));
        sent++;
      end
      if ($urandom_range(99) < 60) begin
        r = $urandom_range(3);
        if (r == 0) fin_seq = $urandom;
        else if (r == 1) fin_seq = rx_expected - $urandom_range(0, 100);
        else fin_seq = rx_expected + $urandom_range(0, 100);
        drive_packet(CMD_FIN, fin_seq, 16'($urandom), 11'($urandom));
        sent++;
        // closed block swallows these
        repeat ($urandom_range(0, 2)) begin
          drive_packet(1'($urandom), $urandom, 16'($urandom), 11'($urandom));
        end
      end
      phase++;
    end
    gaps_on = 1'b1;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      fault_count++;
    end
  endtask

  always @(posedge clk) begin : watch_results
    window_result_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (ack_release_q.size() == 0) begin
        $error("result transaction with none pending: kind 0x%0h", out_kind);
        fault_count++;
      end else begin
        want = ack_release_q.pop_front();
        check_field("kind", want.kind, out_kind);
        check_field("release_tag", want.tag, out_release_tag);
        check_field("release_len", want.len, out_release_len);
        check_field("own_seq", want.own_seq, out_own_seq);
        check_field("ack_number", want.ack_number, out_ack_number);
        check_field("free_window", want.free_win, out_free_window);
        check_field("sack_map", want.sack, out_sack_map);
        check_field("last", want.last, out_last);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid === 1'b1 || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("selective_repeat_receive_window regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rx_window_size = 6'd32;
    rx_local_seq = '0;
    reopen_window('0);
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_edges();
    test_window_shrink();
    test_full_window_drain();
    test_random_traffic();
    start <= 1'b0;
    while (ack_release_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fault_count == 0 && ack_release_q.size() == 0) begin
      $display("selective_repeat_receive_window regression: pass");
    end else begin
      $display("selective_repeat_receive_window regression: fail");
    end
    $finish;
  end

endmodule

// ===== selective_repeat_receive_window.f =====
hdl/srrw_pkg.sv
hdl/srrw_cell.sv
hdl/selective_repeat_receive_window.sv
tb/testbench.sv
